// ----- design/lzw_byte_encoder_core_assert.svh -----
// Assertion macros shared by the LZW byte encoder RTL.
`ifndef LZW_BYTE_ENCODER_CORE_ASSERT_SVH
`define LZW_BYTE_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every edge out of reset.
`define LZWBE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LZWBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/lzwbe_pkg.sv -----
// Shared constants and control/status types of the LZW byte encoder.
`timescale 1ns / 1ps
package lzwbe_pkg;

  localparam int CODE_BITS_DEF = 12;
  localparam int FIRST_FREE    = 256;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic set_first;
    logic hash_init;
    logic ht_rd;
    logic dict_rd;
    logic step;
    logic take_hit;
    logic insert;
    logic emit_miss;
    logic emit_last;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic have_prefix;
    logic last;
    logic probe_valid;
    logic probe_hit;
    logic out_free;
  } stat_t;

endpackage

// ----- design/lzwbe_stream_if.sv -----
// Valid/ready stream interfaces for byte requests and code results.
`timescale 1ns / 1ps
interface lzwbe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;
  modport source (output valid, in_byte, end_of_stream, input ready);
  modport sink   (input valid, in_byte, end_of_stream, output ready);
endinterface

interface lzwbe_out_if #(
  parameter int CODE_BITS = lzwbe_pkg::CODE_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [CODE_BITS-1:0] code;
  logic                 last_code;
  modport source (output valid, code, last_code, input ready);
  modport sink   (input valid, code, last_code, output ready);
endinterface

// ----- design/lzwbe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lzwbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/lzwbe_dp.sv -----
// Datapath: prefix state, hash table and dictionary memories, result register.
`timescale 1ns / 1ps
module lzwbe_dp #(
  parameter int CODE_BITS = lzwbe_pkg::CODE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lzwbe_pkg::cmd_t      cmd,
  output lzwbe_pkg::stat_t     st,
  input  logic [7:0]           in_byte,
  input  logic                 end_of_stream,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CODE_BITS-1:0] out_code,
  output logic                 out_last
);

  localparam int HW = CODE_BITS + 1;       // hash slot index width
  localparam int KW = CODE_BITS + 8;       // key: prefix code and byte
  localparam int DW = KW + HW;             // dictionary word: key and owning slot
  localparam int HT_DEPTH = 1 << HW;
  localparam int DICT_DEPTH = 1 << CODE_BITS;
  localparam logic [CODE_BITS-1:0] FIRST_CODE = CODE_BITS'(lzwbe_pkg::FIRST_FREE);
  localparam logic [CODE_BITS:0]   FIRST_NEXT = (CODE_BITS + 1)'(lzwbe_pkg::FIRST_FREE);

  logic [7:0]           byte_r;
  logic                 last_r;
  logic [CODE_BITS-1:0] prefix_r;
  logic                 have_r;
  logic [CODE_BITS:0]   nfree_r;
  logic [HW-1:0]        slot_r;
  logic                 out_valid_r;
  logic [CODE_BITS-1:0] out_code_r;
  logic                 out_last_r;

  logic [KW-1:0]        key;
  logic [HW-1:0]        hash;
  logic                 full;
  logic                 wr_en;
  logic [CODE_BITS-1:0] ht_q;
  logic [DW-1:0]        dict_q;

  // Key and folded hash
  assign key  = {prefix_r, byte_r};
  assign hash = key[HW-1:0] ^ {{(HW - (KW - HW)){1'b0}}, key[KW-1:HW]};
  assign full = nfree_r[CODE_BITS];
  assign wr_en = cmd.insert && !full;

  // Hash table: slot -> code
  lzwbe_ram #(.WIDTH(CODE_BITS), .DEPTH(HT_DEPTH)) u_ht (
    .clk  (clk),
    .we   (wr_en),
    .waddr(slot_r),
    .wdata(nfree_r[CODE_BITS-1:0]),
    .re   (cmd.ht_rd),
    .raddr(slot_r),
    .rdata(ht_q)
  );

  // Dictionary: code -> key and the slot that owns it
  lzwbe_ram #(.WIDTH(DW), .DEPTH(DICT_DEPTH)) u_dict (
    .clk  (clk),
    .we   (wr_en),
    .waddr(nfree_r[CODE_BITS-1:0]),
    .wdata({key, slot_r}),
    .re   (cmd.dict_rd),
    .raddr(ht_q),
    .rdata(dict_q)
  );

  // A slot is live only if its code was added this stream and points back to it
  always_comb begin
    st.have_prefix = have_r;
    st.last        = last_r;
    st.probe_valid = (ht_q >= FIRST_CODE) && ({1'b0, ht_q} < nfree_r) &&
                     (dict_q[HW-1:0] == slot_r);
    st.probe_hit   = (dict_q[DW-1:HW] == key);
    st.out_free    = !out_valid_r || out_ready;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r    <= '0;
      have_r      <= 1'b0;
      nfree_r     <= FIRST_NEXT;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.set_first) begin
        prefix_r <= CODE_BITS'(byte_r);
        have_r   <= 1'b1;
      end
      if (cmd.take_hit) begin
        prefix_r <= ht_q;
      end
      if (wr_en) begin
        nfree_r <= nfree_r + 1'b1;
      end
      if (cmd.emit_miss) begin
        prefix_r <= CODE_BITS'(byte_r);
      end
      if (cmd.emit_last) begin
        prefix_r <= '0;
        have_r   <= 1'b0;
        nfree_r  <= FIRST_NEXT;
      end
      if (cmd.emit_miss || cmd.emit_last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      byte_r <= in_byte;
      last_r <= end_of_stream;
    end
    if (cmd.hash_init) begin
      slot_r <= hash;
    end else if (cmd.step) begin
      slot_r <= slot_r + 1'b1;
    end
    if (cmd.emit_miss || cmd.emit_last) begin
      out_code_r <= prefix_r;
      out_last_r <= cmd.emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_code  = out_code_r;
  assign out_last  = out_last_r;

endmodule

// ----- design/lzwbe_ctrl.sv -----
// Controller: sequences input, hash probes, insertion and result emission.
`timescale 1ns / 1ps
module lzwbe_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lzwbe_pkg::stat_t st,
  output lzwbe_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_LOOK  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_TAIL  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_START;
        end
      end
      S_START: begin
        if (st.have_prefix) begin
          cmd.hash_init = 1'b1;
          state_nxt     = S_PROBE;
        end else begin
          cmd.set_first = 1'b1;
          state_nxt     = S_TAIL;
        end
      end
      S_PROBE: begin
        cmd.ht_rd = 1'b1;
        state_nxt = S_LOOK;
      end
      S_LOOK: begin
        cmd.dict_rd = 1'b1;
        state_nxt   = S_CHECK;
      end
      S_CHECK: begin
        // an empty or stale slot ends the probe chain as a miss
        if (st.probe_valid && st.probe_hit) begin
          cmd.take_hit = 1'b1;
          state_nxt    = S_TAIL;
        end else if (st.probe_valid) begin
          cmd.step  = 1'b1;
          state_nxt = S_PROBE;
        end else begin
          cmd.insert = 1'b1;
          state_nxt  = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit_miss = 1'b1;
          state_nxt     = S_TAIL;
        end
      end
      S_TAIL: begin
        if (!st.last) begin
          state_nxt = S_IDLE;
        end else if (st.out_free) begin
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/lzw_byte_encoder_core.sv -----
// LZW byte encoder, 12-bit codes by default: byte requests in, codes out.
// Usage:
//   in_req carries one byte per request plus end_of_stream on the last byte
//   of a stream. out_res carries emitted codes; last_code marks the final
//   code of a stream, after which the dictionary starts over.
// Sequencing (one request at a time):
//   first byte of a stream: S_IDLE takes it and S_START makes it the prefix;
//   other bytes: S_START, then S_PROBE, S_LOOK and S_CHECK for each hash probe
//   (linear probing in a table twice the dictionary size, so probe chains stay
//   short); a miss inserts the new string in S_CHECK and emits a code in S_EMIT.
//   The final code of a stream is emitted from S_TAIL. The probe loop runs
//   through the hash table RAM and dictionary RAM, each with registered reads.
// Reset (rst_n low, synchronous): dictionary empty, no prefix, next code
//   256, no result pending. No memory clearing is needed; stale table slots
//   are recognized by their code range and a back-pointer in the dictionary.
// Stall: a result waits in the output register while out_res.ready is low;
//   the encoder holds further emission and accepts no new byte until the
//   pending work of the current request is done.
`timescale 1ns / 1ps
`include "lzw_byte_encoder_core_assert.svh"
module lzw_byte_encoder_core #(
  parameter int CODE_BITS = lzwbe_pkg::CODE_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  lzwbe_in_if.sink    in_req,
  lzwbe_out_if.source out_res
);

  lzwbe_pkg::cmd_t  cmd;
  lzwbe_pkg::stat_t st;
  logic             in_ready;

  lzwbe_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_req.valid),
    .in_ready(in_ready),
    .st      (st),
    .cmd     (cmd)
  );

  lzwbe_dp #(.CODE_BITS(CODE_BITS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .st           (st),
    .in_byte      (in_req.in_byte),
    .end_of_stream(in_req.end_of_stream),
    .out_valid    (out_res.valid),
    .out_ready    (out_res.ready),
    .out_code     (out_res.code),
    .out_last     (out_res.last_code)
  );

  assign in_req.ready = in_ready;

  // Checks
  `LZWBE_ASSERT_NEXT(a_busy_after_req, in_req.valid && in_ready, !in_ready,
    "encoder took a request while still busy")
  `LZWBE_ASSERT_SAME(a_emit_has_room, cmd.emit_miss || cmd.emit_last, st.out_free,
    "code emitted over a pending result")
  `LZWBE_ASSERT_NEXT(a_hold_on_stall, out_res.valid && !out_res.ready,
    out_res.valid && $stable(out_res.code) && $stable(out_res.last_code),
    "result changed while stalled")

endmodule
